>>> design/lrcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcp_pkg: shared types and constants for the lidar ring/column projection
// Field widths, quadrant codes, the CORDIC arctangent table in turns and the
// transaction types passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package lrcp_pkg;

   localparam int XY_W        = 24;
   localparam int RING_OUT_W  = 6;
   localparam int COL_W       = 12;
   localparam int WIDTH_W     = 13;
   localparam int CORDIC_STEPS = 28;
   localparam int STEP_W      = 5;
   localparam int CORDIC_W    = 28;
   localparam int ACC_W       = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   localparam logic [RING_OUT_W-1:0] RING_OUT_MAX = 6'd63;
   localparam logic [COL_W-1:0]      COL_MAX      = 12'd4095;
   localparam logic [WIDTH_W-1:0]    WIDTH_RESET  = 13'd2083;
   localparam logic [ACC_W-1:0]      HALF_TURN    = 32'h8000_0000;

   typedef enum logic [2:0] {
      QUAD_NONE = 3'd0,
      QUAD_1    = 3'd1,
      QUAD_2    = 3'd2,
      QUAD_3    = 3'd3,
      QUAD_4    = 3'd4
   } quad_type;

   localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [RING_OUT_W-1:0]  ring;
      logic                   origin;
   } point_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic [ACC_W-1:0]           acc;
      logic [RING_OUT_W-1:0]      ring;
      logic                       origin;
   } vec_type;

   // One vectoring step: rotate toward y = 0, accumulate the angle in turns.
   function automatic vec_type cordic_step(vec_type s, logic [STEP_W-1:0] idx);
      vec_type r;
      logic signed [CORDIC_W-1:0] xs;
      logic signed [CORDIC_W-1:0] ys;
      r  = s;
      xs = s.x >>> idx;
      ys = s.y >>> idx;
      if (!s.y[CORDIC_W-1]) begin
         r.x   = s.x + ys;
         r.y   = s.y - xs;
         r.acc = s.acc + ATAN_TURNS[idx];
      end else begin
         r.x   = s.x - ys;
         r.y   = s.y + xs;
         r.acc = s.acc - ATAN_TURNS[idx];
      end
      return r;
   endfunction

endpackage

>>> design/lidar_ring_and_column_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_ring_and_column_projection: lidar point to range image row/column
// Pipeline: queue, fold stage, 28 CORDIC stages (one pipelined stage per step),
// rounding, multiply and output register between an accepted point and result.
// Throughput: one point per cycle unless rsp_ready stalls the pipeline.
// Reset: synchronous; clears ring tracking to the top ring, empties the queue
// and pipeline, and sets image_width to 2083.
// ----------------------------------------------------------------------------
module lidar_ring_and_column_projection
   import lrcp_pkg::*;
#(
   parameter int RING_COUNT = 64,
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [XY_W-1:0] req_x_pos,
   input  logic signed [XY_W-1:0] req_y_pos,
   input  logic                   req_scan_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RING_OUT_W-1:0]  rsp_ring_index,
   output logic [COL_W-1:0]       rsp_column_index,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [WIDTH_W-1:0]     csr_data
);

   logic [WIDTH_W-1:0] image_width_ff;
   logic               push_valid, push_ready;
   point_type          push_data;
   logic               pop_valid, pop_ready;
   point_type          pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         image_width_ff <= csr_data;
      end
   end

   lrcp_front #(
      .RING_COUNT (RING_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_scan_start (req_scan_start),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   lrcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lrcp_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .image_width      (image_width_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ring_index   (rsp_ring_index),
      .rsp_column_index (rsp_column_index)
   );

endmodule

>>> design/lrcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcp_front: point classification and ring tracking
// Sorts each point into a quadrant, steps the ring down on a quadrant 4 to
// quadrant 1 crossing and hands the tagged point to the queue.
// ----------------------------------------------------------------------------
module lrcp_front
   import lrcp_pkg::*;
#(
   parameter int RING_COUNT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [XY_W-1:0] req_x_pos,
   input  logic signed [XY_W-1:0] req_y_pos,
   input  logic                   req_scan_start,
   output logic                   push_valid,
   input  logic                   push_ready,
   output point_type              push_data
);

   localparam int RING_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
   localparam logic [RING_W-1:0] RING_TOP = RING_W'(RING_COUNT - 1);

   logic [RING_W-1:0] ring_ff, ring_in;
   quad_type          last_quad_ff, last_quad_in;

   logic [RING_W-1:0] base_ring;
   quad_type          base_quad;
   quad_type          quad;
   logic              x_pos_gt0, x_neg, y_pos_gt0, y_neg;
   logic [8:0]        ring_wide;
   logic              accept;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   assign x_neg     = req_x_pos[XY_W-1];
   assign y_neg     = req_y_pos[XY_W-1];
   assign x_pos_gt0 = !x_neg && (req_x_pos != '0);
   assign y_pos_gt0 = !y_neg && (req_y_pos != '0);

   always_comb begin
      if (x_pos_gt0 && !y_neg) begin
         quad = QUAD_1;
      end else if (!x_pos_gt0 && y_pos_gt0) begin
         quad = QUAD_2;
      end else if (x_neg && !y_pos_gt0) begin
         quad = QUAD_3;
      end else if (!x_neg && y_neg) begin
         quad = QUAD_4;
      end else begin
         quad = QUAD_NONE;
      end
   end

   always_comb begin
      base_ring = req_scan_start ? RING_TOP : ring_ff;
      base_quad = req_scan_start ? QUAD_NONE : last_quad_ff;
      ring_in   = base_ring;
      if (quad == QUAD_1 && base_quad == QUAD_4 && base_ring != '0) begin
         ring_in = base_ring - RING_W'(1);
      end
      last_quad_in = quad;
   end

   assign ring_wide = 9'(ring_in);

   always_comb begin
      push_data.x      = req_x_pos;
      push_data.y      = req_y_pos;
      push_data.origin = (quad == QUAD_NONE);
      push_data.ring   = (ring_wide > 9'(RING_OUT_MAX)) ? RING_OUT_MAX
                                                         : ring_wide[RING_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff      <= RING_TOP;
         last_quad_ff <= QUAD_NONE;
      end else if (accept) begin
         ring_ff      <= ring_in;
         last_quad_ff <= last_quad_in;
      end
   end

endmodule

>>> design/lrcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcp_queue: short transaction queue between front and back end
// Small circular buffer so that each side can stall on its own.
// ----------------------------------------------------------------------------
module lrcp_queue
   import lrcp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  point_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output point_type pop_data
);

   point_type             store_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/lrcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcp_back: azimuth CORDIC and column scaling pipeline
// Half-turn fold, one vectoring CORDIC step per stage, rounding to the angle
// width, multiply by (width-1), round and saturate into the output register.
// ----------------------------------------------------------------------------
module lrcp_back
   import lrcp_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [WIDTH_W-1:0]        image_width,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  point_type                 pop_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RING_OUT_W-1:0]     rsp_ring_index,
   output logic [COL_W-1:0]          rsp_column_index
);

   localparam int PROD_W = WIDTH_W + ANGLE_BITS;
   localparam logic [ACC_W:0]  ACC_HALF  = (ACC_W+1)'(1) << (ACC_W - 1 - ANGLE_BITS);
   localparam logic [PROD_W:0] PROD_HALF = (PROD_W+1)'(1) << (ANGLE_BITS - 1);

   logic    advance;

   vec_type stage_ff [CORDIC_STEPS+1];
   vec_type stage_in [CORDIC_STEPS+1];
   logic    stage_vld_ff [CORDIC_STEPS+1];

   logic [ANGLE_BITS-1:0] frac_ff, frac_in;
   logic [RING_OUT_W-1:0] frac_ring_ff;
   logic                  frac_vld_ff;

   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [RING_OUT_W-1:0] prod_ring_ff;
   logic                  prod_vld_ff;

   logic                  out_vld_ff;
   logic [RING_OUT_W-1:0] out_ring_ff;
   logic [COL_W-1:0]      out_col_ff, out_col_in;

   logic signed [CORDIC_W-1:0] x_ext, y_ext;
   logic [ACC_W:0]             acc_sum;
   logic [WIDTH_W-1:0]         scale;
   logic [PROD_W:0]            prod_rnd;
   logic [PROD_W-ANGLE_BITS:0] col_wide;

   assign advance   = !out_vld_ff || rsp_ready;
   assign pop_ready = advance;

   assign x_ext = {{(CORDIC_W-XY_W){pop_data.x[XY_W-1]}}, pop_data.x};
   assign y_ext = {{(CORDIC_W-XY_W){pop_data.y[XY_W-1]}}, pop_data.y};

   always_comb begin
      stage_in[0].ring   = pop_data.ring;
      stage_in[0].origin = pop_data.origin;
      if (x_ext[CORDIC_W-1]) begin
         stage_in[0].x   = -x_ext;
         stage_in[0].y   = -y_ext;
         stage_in[0].acc = HALF_TURN;
      end else begin
         stage_in[0].x   = x_ext;
         stage_in[0].y   = y_ext;
         stage_in[0].acc = '0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         stage_in[i+1] = cordic_step(stage_ff[i], STEP_W'(i));
      end
   end

   always_comb begin
      acc_sum = {1'b0, stage_ff[CORDIC_STEPS].acc} + ACC_HALF;
      frac_in = stage_ff[CORDIC_STEPS].origin ? '0 : acc_sum[ACC_W-1 -: ANGLE_BITS];
   end

   always_comb begin
      scale   = (image_width < WIDTH_W'(2)) ? '0 : image_width - WIDTH_W'(1);
      prod_in = PROD_W'(scale) * PROD_W'(frac_ff);
   end

   always_comb begin
      prod_rnd   = {1'b0, prod_ff} + PROD_HALF;
      col_wide   = prod_rnd[PROD_W:ANGLE_BITS];
      out_col_in = (col_wide > (PROD_W-ANGLE_BITS+1)'(COL_MAX)) ? COL_MAX
                                                                : col_wide[COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            stage_vld_ff[i] <= 1'b0;
         end
         frac_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (advance) begin
         stage_vld_ff[0] <= pop_valid;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            stage_vld_ff[i+1] <= stage_vld_ff[i];
         end
         frac_vld_ff <= stage_vld_ff[CORDIC_STEPS];
         prod_vld_ff <= frac_vld_ff;
         out_vld_ff  <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         frac_ff      <= frac_in;
         frac_ring_ff <= stage_ff[CORDIC_STEPS].ring;
         prod_ff      <= prod_in;
         prod_ring_ff <= frac_ring_ff;
         out_col_ff   <= out_col_in;
         out_ring_ff  <= prod_ring_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_ring_index   = out_ring_ff;
   assign rsp_column_index = out_col_ff;

endmodule

>>> design/lrcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcp_checker: port-level checks for the projection block
// Watches the top level ports only; attached by bind.
// ----------------------------------------------------------------------------
module lrcp_checker
   import lrcp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [RING_OUT_W-1:0] rsp_ring_index,
   input logic [COL_W-1:0]      rsp_column_index,
   input logic                  csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ring_index)
                                  && $stable(rsp_column_index))
      else $error("result transaction dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready && csr_ready)
      else $error("block not ready for transactions after reset");

endmodule

bind lidar_ring_and_column_projection lrcp_checker u_lrcp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_ring_index   (rsp_ring_index),
   .rsp_column_index (rsp_column_index),
   .csr_ready        (csr_ready)
);
